FILE: sv/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Types, constants and the alphabet lookup for the GSM septet packer.
// ----------------------------------------------------------------------------
package gsp_pkg;

  localparam int unsigned OCTET_W  = 8;
  localparam int unsigned SEPTET_W = 7;
  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned ALPHA_N  = 128;
  localparam int unsigned QDEPTH   = 2;

  localparam logic [UNIT_W-1:0] ESC_UNIT = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              last_unit;
  } in_item_t;

  typedef struct packed {
    logic [OCTET_W-1:0] octet;
    logic               last_octet;
    status_e            status;
    logic [COUNT_W-1:0] septet_count;
  } result_t;

  // one accepted item that produced results: res0 always, res1 when two
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } job_t;

  typedef struct packed {
    logic                hit;
    logic [SEPTET_W-1:0] code;
  } lookup_t;

  localparam logic [UNIT_W-1:0] GSM_ALPHA [ALPHA_N] = '{
    16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
    16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
    16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
    16'h03A3, 16'h0398, 16'h039E, ESC_UNIT, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
    16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
    16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
  };

  function automatic lookup_t gsm_lookup(logic [UNIT_W-1:0] cu);
    lookup_t r;
    r = '0;
    for (int i = 0; i < ALPHA_N; i++) begin
      if (GSM_ALPHA[i] == cu) begin
        r.hit  = 1'b1;
        r.code = SEPTET_W'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/gsp_if.sv
// ----------------------------------------------------------------------------
// gsp_if
// Valid/ready channels of the GSM septet packer: input, job and result.
// ----------------------------------------------------------------------------
interface gsp_in_if;
  import gsp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface gsp_job_if;
  import gsp_pkg::*;
  logic valid;
  logic ready;
  job_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface gsp_out_if;
  import gsp_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/gsp_front.sv
// ----------------------------------------------------------------------------
// gsp_front
// Classifies each code unit, packs septets and issues one job per request
// that yields results.
// ----------------------------------------------------------------------------
module gsp_front #(
  parameter int unsigned MAX_CHARS = 160
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  gsp_in_if.sink    in_i,
  gsp_job_if.source job_o
);
  import gsp_pkg::*;

  logic [OCTET_W-1:0]  pend_q, pend_d;
  logic [2:0]          off_q, off_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic                disc_q, disc_d;

  lookup_t             lk;
  logic                too_long;
  logic [COUNT_W-1:0]  cnt_inc;
  logic [14:0]         acc;
  logic [OCTET_W-1:0]  pend_pack;
  logic [2:0]          off_pack;
  logic                has_res;
  logic                accept;
  job_t                job;

  assign lk       = gsm_lookup(in_i.payload.code_unit);
  assign too_long = cnt_q >= COUNT_W'(MAX_CHARS);
  assign cnt_inc  = cnt_q + 1'b1;
  assign acc      = {7'b0, pend_q} | (15'(lk.code) << off_q);
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    if (off_q != 3'd0) begin
      pend_pack = {1'b0, acc[14:8]};
      off_pack  = off_q - 3'd1;
    end else begin
      pend_pack = acc[7:0];
      off_pack  = 3'd7;
    end
  end

  always_comb begin
    job     = '0;
    has_res = 1'b0;
    pend_d  = pend_q;
    off_d   = off_q;
    cnt_d   = cnt_q;
    disc_d  = disc_q;
    if (disc_q) begin
      if (in_i.payload.last_unit) begin
        disc_d = 1'b0;
      end
    end else if (too_long || !lk.hit) begin
      has_res                = 1'b1;
      job.res0.last_octet    = 1'b1;
      job.res0.status        = too_long ? ST_TOO_LONG : ST_UNMAPPED;
      pend_d                 = '0;
      off_d                  = '0;
      cnt_d                  = '0;
      disc_d                 = !in_i.payload.last_unit;
    end else begin
      cnt_d  = cnt_inc;
      pend_d = pend_pack;
      off_d  = off_pack;
      if (off_q != 3'd0) begin
        has_res        = 1'b1;
        job.res0.octet = acc[7:0];
      end
      if (in_i.payload.last_unit) begin
        if (off_pack != 3'd0) begin
          if (off_q != 3'd0) begin
            job.two                = 1'b1;
            job.res1.octet         = pend_pack;
            job.res1.last_octet    = 1'b1;
            job.res1.septet_count  = cnt_inc;
          end else begin
            has_res                = 1'b1;
            job.res0.octet         = pend_pack;
            job.res0.last_octet    = 1'b1;
            job.res0.septet_count  = cnt_inc;
          end
        end else begin
          job.res0.last_octet   = 1'b1;
          job.res0.septet_count = cnt_inc;
        end
        pend_d = '0;
        off_d  = '0;
        cnt_d  = '0;
      end
    end
  end

  assign in_i.ready    = job_o.ready;
  assign job_o.valid   = in_i.valid && has_res;
  assign job_o.payload = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      off_q  <= '0;
      cnt_q  <= '0;
      disc_q <= 1'b0;
    end else if (accept) begin
      pend_q <= pend_d;
      off_q  <= off_d;
      cnt_q  <= cnt_d;
      disc_q <= disc_d;
    end
  end

endmodule

FILE: sv/gsp_queue.sv
// ----------------------------------------------------------------------------
// gsp_queue
// Short job queue that decouples the packing front from the result back.
// ----------------------------------------------------------------------------
module gsp_queue (
  input  logic  clk_i,
  input  logic  rst_ni,
  gsp_job_if.sink   push_i,
  gsp_job_if.source pop_o
);
  import gsp_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  job_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push = push_i.valid && push_i.ready;
  assign pop  = pop_o.valid && pop_o.ready;

  assign push_i.ready  = cnt_q != CNT_W'(QDEPTH);
  assign pop_o.valid   = cnt_q != '0;
  assign pop_o.payload = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: sv/gsp_back.sv
// ----------------------------------------------------------------------------
// gsp_back
// Drains jobs into the result channel, one result per cycle while the receiver
// is ready, through an output register with a second slot for the flush result.
// ----------------------------------------------------------------------------
module gsp_back (
  input  logic  clk_i,
  input  logic  rst_ni,
  gsp_job_if.sink   job_i,
  gsp_out_if.source out_o
);
  import gsp_pkg::*;

  logic    out_valid_q;
  result_t out_q;
  logic    sec_valid_q;
  result_t sec_q;
  logic    load;
  logic    shift;

  assign shift = sec_valid_q && out_o.ready;
  assign load  = !sec_valid_q && (!out_valid_q || out_o.ready);

  assign job_i.ready   = load;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (shift) begin
      sec_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= job_i.valid;
      sec_valid_q <= job_i.valid && job_i.payload.two;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      out_q <= sec_q;
    end else if (load && job_i.valid) begin
      out_q <= job_i.payload.res0;
      sec_q <= job_i.payload.res1;
    end
  end

  // second slot only ever sits behind a presented result
  a_sec_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_valid_q |-> out_valid_q)
    else $error("flush result pending without a presented result");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |->
      (out_q.octet == '0 && out_q.last_octet && out_q.septet_count == '0))
    else $error("error result not zero and final");

  a_count_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.septet_count != '0) |-> out_q.last_octet)
    else $error("septet count on a non-final result");

  a_flush_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.ready && sec_valid_q) |=> (out_valid_q && out_q.last_octet))
    else $error("flush result not marked final");

endmodule

FILE: sv/gsm_septet_packer_core.sv
// ----------------------------------------------------------------------------
// gsm_septet_packer_core
// GSM 7-bit default alphabet encoder packing septets LSB-first into octets.
// ----------------------------------------------------------------------------
// Path: each result passes through the job queue and then the output register.
// Throughput: one request per cycle while the job queue has room; the result
//   port moves one result per cycle while ready, so a last character with two
//   results stalls the back end, and the two-entry job queue absorbs that.
// Reset: clears packing state, character count, discard flag, queue and
//   output valid.
module gsm_septet_packer_core #(
  parameter int unsigned MAX_CHARS = 160
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  gsp_in_if.sink    in_i,
  gsp_out_if.source out_o
);
  import gsp_pkg::*;

  gsp_job_if fq_if ();
  gsp_job_if qb_if ();

  gsp_front #(
    .MAX_CHARS (MAX_CHARS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .job_o  (fq_if)
  );

  gsp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fq_if),
    .pop_o  (qb_if)
  );

  gsp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (qb_if),
    .out_o  (out_o)
  );

endmodule
